// ===== design/luhn_pkg.sv =====
// Shared types, constants and helper functions for the Luhn ID number validator.
package luhn_pkg;

  localparam int unsigned NUM_W          = 30;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BCD_DIGITS     = 10;
  localparam int unsigned BCD_W          = BCD_DIGITS * DIGIT_W;
  localparam int unsigned BITS_PER_STAGE = 5;
  localparam int unsigned BCD_STAGES     = NUM_W / BITS_PER_STAGE;
  localparam int unsigned SUM_W          = 7;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [NUM_W-1:0] LOWER_RESET = NUM_W'(100000000);
  localparam logic [NUM_W-1:0] UPPER_RESET = NUM_W'(999999999);

  typedef enum logic [0:0] {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_idx_e;

  // Payload carried through the binary to BCD conversion stages.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [BCD_W-1:0] bcd;
    logic             names_ok;
    logic             in_range;
  } stage_t;

  // Double dabble correction: a digit of five or more gets three added before the shift.
  function automatic logic [DIGIT_W-1:0] luhn_adjust(input logic [DIGIT_W-1:0] d);
    luhn_adjust = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
  endfunction

  // Digit sum of twice a decimal digit.
  function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] twice;
    twice = {d, 1'b0};
    luhn_double = (d >= DIGIT_W'(5)) ? DIGIT_W'(twice - 5'd9) : twice[DIGIT_W-1:0];
  endfunction

  // Remainder by ten of a small sum, by a chain of compare and subtract steps.
  function automatic logic [DIGIT_W-1:0] luhn_mod10(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = v;
    if (r >= SUM_W'(80)) r = r - SUM_W'(80);
    if (r >= SUM_W'(40)) r = r - SUM_W'(40);
    if (r >= SUM_W'(20)) r = r - SUM_W'(20);
    if (r >= SUM_W'(10)) r = r - SUM_W'(10);
    luhn_mod10 = r[DIGIT_W-1:0];
  endfunction

endpackage

// ===== design/luhn_bcd_stage.sv =====
// One pipeline stage of the binary to BCD conversion: several double dabble steps.
module luhn_bcd_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  luhn_pkg::stage_t                     data_i,
  input  logic [luhn_pkg::BITS_PER_STAGE-1:0]  bits_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output luhn_pkg::stage_t                     data_o
);

  logic             valid_q;
  luhn_pkg::stage_t data_q, data_d;
  logic             load;

  always_comb begin
    logic [luhn_pkg::BCD_W-1:0] bcd;
    bcd = data_i.bcd;
    // Bits enter most significant first.
    for (int s = 0; s < luhn_pkg::BITS_PER_STAGE; s++) begin
      for (int k = 0; k < luhn_pkg::BCD_DIGITS; k++) begin
        bcd[k*luhn_pkg::DIGIT_W +: luhn_pkg::DIGIT_W] =
          luhn_pkg::luhn_adjust(bcd[k*luhn_pkg::DIGIT_W +: luhn_pkg::DIGIT_W]);
      end
      bcd = {bcd[luhn_pkg::BCD_W-2:0], bits_i[luhn_pkg::BITS_PER_STAGE-1-s]};
    end
    data_d     = data_i;
    data_d.bcd = bcd;
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/luhn_id_number_validator.sv =====
// Throughput: one beat per cycle; six stages of five double dabble steps convert the
// number to decimal, one stage adds the Luhn digit sum, one stage forms the result.
// Each stage stalls only when it holds a beat the next stage cannot take.
// Reset clears all stage valid bits and loads the default bounds.
module luhn_id_number_validator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: id_number[29:0], family_present[30], given_present[31]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [luhn_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // tdata: in_range[0], check_ok[1], accepted[2], stored_number[32:3], zero[39:33]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [luhn_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [luhn_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [luhn_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [luhn_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned NS = luhn_pkg::BCD_STAGES;
  localparam int unsigned DW = luhn_pkg::DIGIT_W;

  // Configuration registers
  logic [luhn_pkg::NUM_W-1:0] lower_q, upper_q;
  luhn_pkg::reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = luhn_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= luhn_pkg::LOWER_RESET;
      upper_q <= luhn_pkg::UPPER_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        luhn_pkg::REG_LOWER: lower_q <= pwdata[luhn_pkg::NUM_W-1:0];
        luhn_pkg::REG_UPPER: upper_q <= pwdata[luhn_pkg::NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      luhn_pkg::REG_LOWER: prdata = luhn_pkg::APB_DATA_W'(lower_q);
      luhn_pkg::REG_UPPER: prdata = luhn_pkg::APB_DATA_W'(upper_q);
      default:             prdata = '0;
    endcase
  end

  // Conversion pipeline
  luhn_pkg::stage_t stage_data  [NS+1];
  logic             stage_valid [NS+1];
  logic             stage_ready [NS+1];
  logic [luhn_pkg::NUM_W-1:0] in_num;

  assign in_num = s_axis_tdata[luhn_pkg::NUM_W-1:0];

  always_comb begin
    stage_data[0].num      = in_num;
    stage_data[0].bcd      = '0;
    stage_data[0].names_ok = s_axis_tdata[luhn_pkg::NUM_W] && s_axis_tdata[luhn_pkg::NUM_W+1];
    stage_data[0].in_range = (in_num > lower_q) && (in_num < upper_q);
  end

  assign stage_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = stage_ready[0];

  for (genvar g = 0; g < NS; g++) begin : g_bcd
    luhn_bcd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .ready_o (stage_ready[g]),
      .data_i  (stage_data[g]),
      .bits_i  (stage_data[g].num[luhn_pkg::NUM_W-1-luhn_pkg::BITS_PER_STAGE*g -:
                                  luhn_pkg::BITS_PER_STAGE]),
      .valid_o (stage_valid[g+1]),
      .ready_i (stage_ready[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  // Digit sum stage
  logic                       sum_valid_q, sum_ready;
  logic [luhn_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [DW-1:0]              check_digit_q;
  logic [luhn_pkg::NUM_W-1:0] sum_num_q;
  logic                       sum_names_q, sum_range_q;

  // Digits at even places from the right are doubled; the check digit is left out.
  always_comb begin
    logic [DW-1:0] d;
    sum_d = '0;
    for (int k = 1; k < luhn_pkg::BCD_DIGITS; k++) begin
      d = stage_data[NS].bcd[k*DW +: DW];
      if (k % 2 == 1) begin
        sum_d = sum_d + luhn_pkg::SUM_W'(luhn_pkg::luhn_double(d));
      end else begin
        sum_d = sum_d + luhn_pkg::SUM_W'(d);
      end
    end
  end

  // Output stage
  logic                       out_valid_q, out_ready;
  logic                       out_range_q, out_check_q, out_acc_q;
  logic [luhn_pkg::NUM_W-1:0] out_num_q;
  logic [DW-1:0]              sum_mod, expected;
  logic                       check_ok, acc;

  assign out_ready         = !out_valid_q || m_axis_tready;
  assign sum_ready         = !sum_valid_q || out_ready;
  assign stage_ready[NS]   = sum_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_ready) sum_valid_q <= stage_valid[NS];
      if (out_ready) out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && stage_valid[NS]) begin
      sum_q         <= sum_d;
      check_digit_q <= stage_data[NS].bcd[DW-1:0];
      sum_num_q     <= stage_data[NS].num;
      sum_names_q   <= stage_data[NS].names_ok;
      sum_range_q   <= stage_data[NS].in_range;
    end
  end

  assign sum_mod  = luhn_pkg::luhn_mod10(sum_q);
  assign expected = (sum_mod == '0) ? '0 : DW'(10) - sum_mod;
  assign check_ok = (check_digit_q == expected);
  assign acc      = check_ok && sum_names_q && sum_range_q;

  always_ff @(posedge clk_i) begin
    if (out_ready && sum_valid_q) begin
      out_range_q <= sum_range_q;
      out_check_q <= check_ok;
      out_acc_q   <= acc;
      out_num_q   <= acc ? sum_num_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = luhn_pkg::M_TDATA_W'({out_num_q, out_acc_q, out_check_q, out_range_q});

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the Luhn ID number validator: stream stimulus, APB setup, result check.
`timescale 1ns / 1ps

module tb;
  import luhn_pkg::*;

  localparam int unsigned PIPE_LATENCY = 8;
  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned MAX_ID = 999999999;
  localparam logic [APB_ADDR_W-1:0] ADDR_LOWER = APB_ADDR_W'(4 * REG_LOWER);
  localparam logic [APB_ADDR_W-1:0] ADDR_UPPER = APB_ADDR_W'(4 * REG_UPPER);

  typedef struct packed {
    logic [NUM_W-1:0] stored;
    logic             accepted;
    logic             check_ok;
    logic             in_range;
  } verdict_t;

  // flags holds {accepted, check_ok, in_range} for rows whose result is typed in.
  typedef struct {
    logic [NUM_W-1:0] id;
    logic             fam;
    logic             giv;
    bit               typed;
    logic [2:0]       flags;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // tdata: id_number[29:0], family_present[30], given_present[31]
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // tdata: in_range[0], check_ok[1], accepted[2], stored_number[32:3], zero[39:33]
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [NUM_W-1:0] bound_lo;
  logic [NUM_W-1:0] bound_hi;
  verdict_t         pending_verdicts[$];
  stim_row_t        directed_rows[$];
  int unsigned      errors;
  int unsigned      cycle_count;
  bit               calm;
  bit               hold_request;

  luhn_id_number_validator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // Digits left of the check digit alternate doubled and plain, starting doubled.
  function automatic logic [3:0] luhn_check_digit(input logic [NUM_W-1:0] num);
    int unsigned rest;
    int unsigned sum;
    int unsigned d;
    bit          twice;
    rest  = num / 10;
    sum   = 0;
    twice = 1'b1;
    while (rest != 0) begin
      d = rest % 10;
      if (twice) begin
        d = 2 * d;
        if (d > 9) d = d - 9;
      end
      sum   += d;
      twice = !twice;
      rest  = rest / 10;
    end
    return 4'((10 - sum % 10) % 10);
  endfunction

  function automatic verdict_t luhn_verdict(input logic [NUM_W-1:0] num, input logic fam,
                                            input logic giv);
    verdict_t v;
    v.in_range = (num > bound_lo) && (num < bound_hi);
    v.check_ok = (num % 10) == luhn_check_digit(num);
    v.accepted = v.in_range && fam && giv && v.check_ok;
    v.stored   = v.accepted ? num : '0;
    return v;
  endfunction

  function automatic void add_row(input logic [NUM_W-1:0] id, input logic fam,
                                  input logic giv, input bit typed, input logic [2:0] flags);
    stim_row_t r;
    r.id    = id;
    r.fam   = fam;
    r.giv   = giv;
    r.typed = typed;
    r.flags = flags;
    directed_rows.push_back(r);
  endfunction

  task automatic send_id(input logic [NUM_W-1:0] id, input logic fam, input logic giv,
                         input verdict_t want);
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {giv, fam, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_verdicts.push_back(want);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [NUM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(input logic [APB_ADDR_W-1:0] addr, input logic [NUM_W-1:0] want,
                           input string what);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DATA_W'(want)) report_mismatch(what, prdata, APB_DATA_W'(want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_bounds(input logic [NUM_W-1:0] lo, input logic [NUM_W-1:0] hi);
    apb_write(ADDR_LOWER, lo);
    apb_write(ADDR_UPPER, hi);
    bound_lo = lo;
    bound_hi = hi;
    apb_check(ADDR_LOWER, bound_lo, "lower_bound readback");
    apb_check(ADDR_UPPER, bound_hi, "upper_bound readback");
  endtask

  task automatic drain();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, plus one long hold-off so the pipeline fills up.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.in_range)
          report_mismatch("in_range", m_axis_tdata[0], want.in_range);
        if (m_axis_tdata[1] !== want.check_ok)
          report_mismatch("check_ok", m_axis_tdata[1], want.check_ok);
        if (m_axis_tdata[2] !== want.accepted)
          report_mismatch("accepted", m_axis_tdata[2], want.accepted);
        if (m_axis_tdata[32:3] !== want.stored)
          report_mismatch("stored_number", m_axis_tdata[32:3], want.stored);
        if (m_axis_tdata[39:33] !== '0)
          report_mismatch("tdata padding", m_axis_tdata[39:33], '0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    verdict_t    want;
    int unsigned lo;
    int unsigned hi;
    int unsigned n;
    int unsigned pick;
    int unsigned roll;
    logic        fam;
    logic        giv;

    errors        = 0;
    cycle_count   = 0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    bound_lo      = LOWER_RESET;
    bound_hi      = UPPER_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_check(ADDR_LOWER, LOWER_RESET, "lower_bound after reset");
    apb_check(ADDR_UPPER, UPPER_RESET, "upper_bound after reset");

    // Directed rows run with the reset bounds.
    add_row(30'd0,          1'b1, 1'b1, 1'b1, 3'b010);
    add_row(30'h3FFF_FFFF,  1'b1, 1'b1, 1'b1, 3'b000);
    add_row(30'd123456782,  1'b1, 1'b1, 1'b1, 3'b111);
    // Digit sum is a multiple of ten, so the check digit is zero.
    add_row(30'd323456780,  1'b1, 1'b1, 1'b1, 3'b111);
    add_row(30'd123456782,  1'b0, 1'b1, 1'b1, 3'b011);
    add_row(30'd123456782,  1'b1, 1'b0, 1'b1, 3'b011);
    add_row(30'd123456782,  1'b0, 1'b0, 1'b1, 3'b011);
    add_row(30'd123456783,  1'b1, 1'b1, 1'b1, 3'b001);
    // A correct check digit below the lower bound is still flagged as correct.
    add_row(30'd46454286,   1'b1, 1'b1, 1'b1, 3'b010);
    add_row(30'd100000000,  1'b1, 1'b1, 1'b0, 3'b000);
    add_row(30'd100000001,  1'b1, 1'b1, 1'b0, 3'b000);
    add_row(30'd999999998,  1'b1, 1'b1, 1'b0, 3'b000);
    add_row(30'd999999999,  1'b1, 1'b1, 1'b0, 3'b000);
    add_row(30'd1000000000, 1'b1, 1'b1, 1'b0, 3'b000);
    add_row(30'd1073741820, 1'b1, 1'b1, 1'b0, 3'b000);
    add_row(30'h2000_0000,  1'b1, 1'b1, 1'b0, 3'b000);
    add_row(30'h1FFF_FFFF,  1'b0, 1'b1, 1'b0, 3'b000);
    add_row(30'h2AAA_AAAA,  1'b1, 1'b0, 1'b0, 3'b000);
    add_row(30'h1555_5555,  1'b1, 1'b1, 1'b0, 3'b000);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        want.in_range = directed_rows[i].flags[0];
        want.check_ok = directed_rows[i].flags[1];
        want.accepted = directed_rows[i].flags[2];
        want.stored   = want.accepted ? directed_rows[i].id : '0;
      end else begin
        want = luhn_verdict(directed_rows[i].id, directed_rows[i].fam, directed_rows[i].giv);
      end
      send_id(directed_rows[i].id, directed_rows[i].fam, directed_rows[i].giv, want);
    end
    s_axis_tvalid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          lo = 0;
          hi = MAX_ID;
        end
        1: begin
          lo = MAX_ID;
          hi = 0;
        end
        2: begin
          lo = 123456781;
          hi = 123456783;
        end
        3: begin
          lo = 500000000;
          hi = 500000000;
        end
        7: begin
          lo = LOWER_RESET;
          hi = UPPER_RESET;
        end
        default: begin
          lo = $urandom_range(MAX_ID);
          hi = $urandom_range(MAX_ID);
          if (p != 6 && lo > hi) begin
            pick = lo;
            lo   = hi;
            hi   = pick;
          end
        end
      endcase
      set_bounds(NUM_W'(lo), NUM_W'(hi));
      calm = (p == 5);
      if (p == 4) hold_request = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(99);
        if (roll < 50) begin
          // Well-formed number: inside the bounds where possible, correct check digit.
          n = (lo < hi) ? $urandom_range(hi, lo) : $urandom_range(MAX_ID);
          n = n / 10 * 10;
          n = n + luhn_check_digit(NUM_W'(n));
        end else if (roll < 70) begin
          pick = $urandom_range(1) ? lo : hi;
          n    = pick + $urandom_range(4) - 2;
        end else begin
          n = $urandom() & 32'h3FFF_FFFF;
        end
        fam  = ($urandom_range(3) != 0);
        giv  = ($urandom_range(3) != 0);
        want = luhn_verdict(NUM_W'(n), fam, giv);
        send_id(NUM_W'(n), fam, giv, want);
      end
      s_axis_tvalid <= 1'b0;
      drain();
      calm = 1'b0;
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
